[design/lossless_predictive_huffman_encoder_defines.svh]
// Assertion macros shared by the checker of the predictive pixel encoder.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef LOSSLESS_PREDICTIVE_HUFFMAN_ENCODER_DEFINES_SVH
`define LOSSLESS_PREDICTIVE_HUFFMAN_ENCODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent, outside reset.
`define LPHE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define LPHE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Property checked at every clock edge, reset included.
`define LPHE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

[design/lphe_pkg.sv]
// Shared constants, types and code tables of the predictive pixel encoder.
// Depends on nothing.
package lphe_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int SEL_W     = 3;
    localparam int CFG_W     = 16;
    localparam int CODE_W    = 13;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
    localparam int PRED_W    = PIX_W + 3;
    localparam int RES_W     = PIX_W + 4;
    localparam int CODE_RANGE = 6;

    typedef enum logic [1:0] {
        REG_PRED_SEL     = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [SEL_W-1:0] {
        PRED_LEFT        = 3'd1,
        PRED_ABOVE       = 3'd2,
        PRED_DIAG        = 3'd3,
        PRED_PLANE       = 3'd4,
        PRED_LEFT_HALF   = 3'd5,
        PRED_ABOVE_HALF  = 3'd6,
        PRED_AVERAGE     = 3'd7
    } pred_sel_t;

    function automatic logic [CODE_W-1:0] code_word(input logic [3:0] idx);
        logic [CODE_W-1:0] w;
        case (idx)
            4'd0:    w = 13'd2731;
            4'd1:    w = 13'd683;
            4'd2:    w = 13'd171;
            4'd3:    w = 13'd43;
            4'd4:    w = 13'd11;
            4'd5:    w = 13'd3;
            4'd6:    w = 13'd1;
            4'd7:    w = 13'd0;
            4'd8:    w = 13'd4;
            4'd9:    w = 13'd20;
            4'd10:   w = 13'd84;
            4'd11:   w = 13'd340;
            4'd12:   w = 13'd1364;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] code_len(input logic [3:0] idx);
        logic [LEN_W-1:0] n;
        case (idx)
            4'd0:    n = 4'd13;
            4'd1:    n = 4'd11;
            4'd2:    n = 4'd9;
            4'd3:    n = 4'd7;
            4'd4:    n = 4'd5;
            4'd5:    n = 4'd3;
            4'd6:    n = 4'd1;
            4'd7:    n = 4'd2;
            4'd8:    n = 4'd4;
            4'd9:    n = 4'd6;
            4'd10:   n = 4'd8;
            4'd11:   n = 4'd10;
            4'd12:   n = 4'd12;
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

[design/lossless_predictive_huffman_encoder.sv]
// Top level of the predictive pixel encoder: line store, predictor and code table.
// Depends on lphe_pkg.
//
//  Port group  | Direction | Handshake            | Carries
//  ------------+-----------+----------------------+----------------------------------------
//  pixel in    | in        | in_valid / in_ready  | pixel
//  code out    | out       | out_valid / out_ready| code_bits, code_length, out_of_range,
//              |           |                      | frame_end
//  config      | in        | cfg_write            | cfg_index, cfg_data
//
// One pixel is taken every cycle while in_ready is high; each result is registered in both stages.
// The line store read issued at acceptance sets the first stage; the second stage predicts,
// codes and writes the pixel back, forwarding it when the next request reads the same column.
// Reset clears counters, neighbour pixels and handshakes; the line store needs no clearing.
// A stall on the output holds both stages and lowers in_ready only when both are full.
module lossless_predictive_huffman_encoder
    import lphe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PIX_W-1:0]    pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CODE_W-1:0]   code_bits,
    output logic [LEN_W-1:0]    code_length,
    output logic                out_of_range,
    output logic                frame_end,
    input  logic                cfg_write,
    input  cfg_index_t          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [PIX_W-1:0]    line_mem [MAX_WIDTH];

    logic [SEL_W-1:0]    sel_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic                fend_next;

    logic                s1_valid_reg;
    logic [PIX_W-1:0]    s1_pixel_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_raw_reg;
    logic                s1_row0_reg;
    logic                s1_col0_reg;
    logic                s1_fend_reg;
    logic                fwd_reg;
    logic [PIX_W-1:0]    fwd_data_reg;
    logic [PIX_W-1:0]    rd_data_reg;

    logic [PIX_W-1:0]    left_reg;
    logic [PIX_W-1:0]    upleft_reg;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   code_bits_reg;
    logic [LEN_W-1:0]    code_length_reg;
    logic                oor_reg;
    logic                fend_reg;

    logic                accept;
    logic                s1_adv;
    logic [CNT_W-1:0]    width_eff;
    logic [CNT_W-1:0]    col_inc;
    logic [HEIGHT_W:0]   height_eff;
    logic [HEIGHT_W:0]   row_inc;

    logic [PIX_W-1:0]         above;
    logic signed [PRED_W-1:0] pa, pb, pc;
    logic signed [PRED_W-1:0] d_bc, d_ac, t_bc, t_ac, half_bc, half_ac, sum_ab;
    logic signed [PRED_W-1:0] pred_sel_val, pred;
    logic signed [RES_W-1:0]  resid;
    logic                     in_range;
    logic [3:0]               code_idx;
    logic [CODE_W-1:0]        code_bits_next;
    logic [LEN_W-1:0]         code_length_next;
    logic                     oor_next;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= SEL_W'(PRED_LEFT);
            width_reg  <= WIDTH_W'(16);
            height_reg <= HEIGHT_W'(16);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PRED_SEL:     sel_reg    <= cfg_data[SEL_W-1:0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Raster counters.
    always_comb
    begin
        if (width_reg == '0)
            width_eff = CNT_W'(1);
        else if (CNT_W'(width_reg) > CNT_W'(MAX_WIDTH))
            width_eff = CNT_W'(MAX_WIDTH);
        else
            width_eff = CNT_W'(width_reg);
        height_eff = (height_reg == '0) ? (HEIGHT_W+1)'(1) : {1'b0, height_reg};
        col_inc    = CNT_W'(col_reg) + CNT_W'(1);
        row_inc    = {1'b0, row_reg} + (HEIGHT_W+1)'(1);
        col_next   = col_inc[COL_W-1:0];
        row_next   = row_reg;
        fend_next  = 1'b0;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = row_inc[HEIGHT_W-1:0];
            if (row_inc >= height_eff)
            begin
                row_next  = '0;
                fend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_raw_reg   <= (row_reg == '0) && (col_reg == '0);
            s1_row0_reg  <= (row_reg == '0);
            s1_col0_reg  <= (col_reg == '0);
            s1_fend_reg  <= fend_next;
            fwd_reg      <= s1_adv && (s1_col_reg == col_reg);
            fwd_data_reg <= s1_pixel_reg;
        end
    end

    // Line store: read at acceptance, written back when the second stage completes.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= s1_pixel_reg;
    end

    // Prediction and coding.
    always_comb
    begin
        above   = fwd_reg ? fwd_data_reg : rd_data_reg;
        pa      = {3'b000, left_reg};
        pb      = {3'b000, above};
        pc      = {3'b000, upleft_reg};
        d_bc    = pb - pc;
        d_ac    = pa - pc;
        t_bc    = d_bc + $signed({{(PRED_W-1){1'b0}}, d_bc[PRED_W-1]});
        t_ac    = d_ac + $signed({{(PRED_W-1){1'b0}}, d_ac[PRED_W-1]});
        half_bc = t_bc >>> 1;
        half_ac = t_ac >>> 1;
        sum_ab  = (pa + pb) >>> 1;
        case (pred_sel_t'(sel_reg))
            PRED_ABOVE:      pred_sel_val = pb;
            PRED_DIAG:       pred_sel_val = pc;
            PRED_PLANE:      pred_sel_val = pa + pb - pc;
            PRED_LEFT_HALF:  pred_sel_val = pa + half_bc;
            PRED_ABOVE_HALF: pred_sel_val = pb + half_ac;
            PRED_AVERAGE:    pred_sel_val = sum_ab;
            default:         pred_sel_val = pa;
        endcase
        if (s1_row0_reg)
            pred = pa;
        else if (s1_col0_reg)
            pred = pb;
        else
            pred = pred_sel_val;
        resid    = $signed({4'b0000, s1_pixel_reg}) - $signed({pred[PRED_W-1], pred});
        in_range = (resid >= -RES_W'(CODE_RANGE)) && (resid <= RES_W'(CODE_RANGE));
        code_idx = 4'(resid + RES_W'(CODE_RANGE));
        if (s1_raw_reg)
        begin
            code_bits_next   = CODE_W'(s1_pixel_reg);
            code_length_next = LEN_W'(PIX_W);
            oor_next         = 1'b0;
        end
        else if (in_range)
        begin
            code_bits_next   = code_word(code_idx);
            code_length_next = code_len(code_idx);
            oor_next         = 1'b0;
        end
        else
        begin
            code_bits_next   = '0;
            code_length_next = '0;
            oor_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                left_reg   <= s1_pixel_reg;
                upleft_reg <= above;
            end
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            code_bits_reg   <= code_bits_next;
            code_length_reg <= code_length_next;
            oor_reg         <= oor_next;
            fend_reg        <= s1_fend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_bits    = code_bits_reg;
    assign code_length  = code_length_reg;
    assign out_of_range = oor_reg;
    assign frame_end    = fend_reg;

endmodule

[design/lphe_checker.sv]
// Port-level checker of the predictive pixel encoder, bound to the top level.
// Depends on lphe_pkg and lossless_predictive_huffman_encoder_defines.svh.
`include "lossless_predictive_huffman_encoder_defines.svh"

module lphe_checker
    import lphe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CODE_W-1:0]   code_bits,
    input  logic [LEN_W-1:0]    code_length,
    input  logic                out_of_range,
    input  logic                frame_end
);

    logic                       out_stall;
    logic [CODE_W+LEN_W+1:0]    out_word;
    logic                       code_empty;
    logic                       len_ok;

    assign out_stall  = out_valid && !out_ready;
    assign out_word   = {code_bits, code_length, out_of_range, frame_end};
    assign code_empty = (code_bits == '0) && (code_length == '0);
    assign len_ok     = (code_length != '0) && (code_length <= LEN_W'(CODE_W));

    `LPHE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result moved")
    `LPHE_ASSERT_SAME(a_oor_empty, out_valid && out_of_range, code_empty, "code not empty")
    `LPHE_ASSERT_SAME(a_code_len, out_valid && !out_of_range, len_ok, "bad code length")
    `LPHE_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_n) |-> !out_valid, "result straight after reset")

endmodule

bind lossless_predictive_huffman_encoder lphe_checker u_lphe_checker (.*);
